>>> hdl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked during reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/hsl2rgb_pkg.sv
package hsl2rgb_pkg;

    localparam int NUM_STAGES = 7;
    localparam int NUM_CH     = 3;

    localparam logic [8:0]  HUE_WRAP    = 9'd360;
    localparam logic [6:0]  PCT_MAX     = 7'd100;
    localparam logic [5:0]  DEG_SEXT    = 6'd60;
    localparam logic [7:0]  DBL_HALF    = 8'd100;
    localparam logic [7:0]  DBL_FULL    = 8'd200;
    localparam logic [19:0] C_SCALE     = 20'd60;
    localparam logic [19:0] L_SCALE     = 20'd6000;
    localparam logic [25:0] BYTE_MUL    = 26'd17;
    localparam logic [25:0] ROUND_BIAS  = 26'd20000;
    localparam logic [38:0] RECIP_625   = 39'd429497;
    localparam logic [10:0] BYTE_MAX    = 11'd255;

    typedef enum logic [2:0] {
        HUE_S0,
        HUE_S1,
        HUE_S2,
        HUE_S3,
        HUE_S4,
        HUE_S5
    } sext_t;

    function automatic sext_t sextant(input logic [8:0] h);
        sext_t s;
        if (h < 9'd60)
            s = HUE_S0;
        else if (h < 9'd120)
            s = HUE_S1;
        else if (h < 9'd180)
            s = HUE_S2;
        else if (h < 9'd240)
            s = HUE_S3;
        else if (h < 9'd300)
            s = HUE_S4;
        else
            s = HUE_S5;
        return s;
    endfunction

    function automatic logic [8:0] sext_base(input sext_t s);
        logic [8:0] b;
        case (s)
            HUE_S0:  b = 9'd0;
            HUE_S1:  b = 9'd60;
            HUE_S2:  b = 9'd120;
            HUE_S3:  b = 9'd180;
            HUE_S4:  b = 9'd240;
            HUE_S5:  b = 9'd300;
            default: b = 9'd0;
        endcase
        return b;
    endfunction

endpackage

>>> hdl/hsl_to_rgb_converter_unit.sv
// HSL to 8-bit RGB converter. Takes hue in whole degrees (360 and up wrap once)
// and saturation and lightness in whole percent (clamped to 100), and returns
// round(255 * channel) per component with ties rounded up, exact to the bit.
// Seven-stage pipeline: one pixel per clock sustained while out_stall is low;
// the divide by 40000 is a shift by 6 and a reciprocal multiply for 625.
// Each stage holds its beat while the one ahead is full and held, so in_stall
// rises only when all seven stages are occupied.
`include "assert_macros.svh"

module hsl_to_rgb_converter_unit
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [8:0] hue_deg,
    input  logic [6:0] sat_pct,
    input  logic [6:0] light_pct,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] red_out,
    output logic [7:0] green_out,
    output logic [7:0] blue_out
);

    logic [hsl2rgb_pkg::NUM_STAGES-1:0] vld_reg;
    logic [hsl2rgb_pkg::NUM_STAGES-1:0] vld_next;
    logic [hsl2rgb_pkg::NUM_STAGES-1:0] rdy;

    // stage 0: wrap, clamp, sextant, triangle, lightness distance
    logic [8:0]         hue_n;
    logic [6:0]         sat_c;
    logic [6:0]         light_c;
    hsl2rgb_pkg::sext_t sext_c;
    logic [8:0]         hoff_c;
    logic [5:0]         tri_c;
    logic [7:0]         dbl_c;
    logic [7:0]         amp_c;

    hsl2rgb_pkg::sext_t sext0_reg;
    logic [5:0]         tri0_reg;
    logic [6:0]         amp0_reg;
    logic [6:0]         sat0_reg;
    logic [6:0]         light0_reg;

    // stage 1: chroma in 1/10000
    logic [13:0]        c10k_next;
    logic [13:0]        c10k1_reg;
    hsl2rgb_pkg::sext_t sext1_reg;
    logic [5:0]         tri1_reg;
    logic [6:0]         light1_reg;

    // stage 2: C, X, L scaled to 1/600000
    logic [19:0]        c_next;
    logic [19:0]        x_next;
    logic [19:0]        l6k_next;
    logic [19:0]        c2_reg;
    logic [19:0]        x2_reg;
    logic [19:0]        l6k2_reg;
    hsl2rgb_pkg::sext_t sext2_reg;

    // stage 3..6 per channel
    logic [19:0] m_c;
    logic [19:0] comp_c [hsl2rgb_pkg::NUM_CH];
    logic [20:0] v3_reg [hsl2rgb_pkg::NUM_CH];
    logic [19:0] a4_reg [hsl2rgb_pkg::NUM_CH];
    logic [10:0] q5_reg [hsl2rgb_pkg::NUM_CH];
    logic [7:0]  out6_reg [hsl2rgb_pkg::NUM_CH];

    // handshake
    always_comb
    begin
        rdy[6] = !vld_reg[6] || !out_stall;
        rdy[5] = !vld_reg[5] || rdy[6];
        rdy[4] = !vld_reg[4] || rdy[5];
        rdy[3] = !vld_reg[3] || rdy[4];
        rdy[2] = !vld_reg[2] || rdy[3];
        rdy[1] = !vld_reg[1] || rdy[2];
        rdy[0] = !vld_reg[0] || rdy[1];
    end

    assign vld_next = (rdy & {vld_reg[hsl2rgb_pkg::NUM_STAGES-2:0], in_valid})
                    | (~rdy & vld_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign in_stall  = !rdy[0];
    assign out_valid = vld_reg[6];

    // stage 0
    always_comb
    begin
        hue_n   = (hue_deg >= hsl2rgb_pkg::HUE_WRAP) ? hue_deg - hsl2rgb_pkg::HUE_WRAP
                                                     : hue_deg;
        sat_c   = (sat_pct > hsl2rgb_pkg::PCT_MAX) ? hsl2rgb_pkg::PCT_MAX : sat_pct;
        light_c = (light_pct > hsl2rgb_pkg::PCT_MAX) ? hsl2rgb_pkg::PCT_MAX : light_pct;
        sext_c  = hsl2rgb_pkg::sextant(hue_n);
        hoff_c  = hue_n - hsl2rgb_pkg::sext_base(sext_c);
        if (sext_c == hsl2rgb_pkg::HUE_S1 || sext_c == hsl2rgb_pkg::HUE_S3 ||
            sext_c == hsl2rgb_pkg::HUE_S5)
        begin
            tri_c = hsl2rgb_pkg::DEG_SEXT - hoff_c[5:0];
        end
        else
        begin
            tri_c = hoff_c[5:0];
        end
        dbl_c = {light_c, 1'b0};
        amp_c = (dbl_c >= hsl2rgb_pkg::DBL_HALF) ? hsl2rgb_pkg::DBL_FULL - dbl_c : dbl_c;
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            sext0_reg  <= sext_c;
            tri0_reg   <= tri_c;
            amp0_reg   <= amp_c[6:0];
            sat0_reg   <= sat_c;
            light0_reg <= light_c;
        end
    end

    // stage 1
    assign c10k_next = {7'd0, amp0_reg} * {7'd0, sat0_reg};

    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            c10k1_reg  <= c10k_next;
            sext1_reg  <= sext0_reg;
            tri1_reg   <= tri0_reg;
            light1_reg <= light0_reg;
        end
    end

    // stage 2
    assign c_next   = {6'd0, c10k1_reg} * hsl2rgb_pkg::C_SCALE;
    assign x_next   = {6'd0, c10k1_reg} * {14'd0, tri1_reg};
    assign l6k_next = {13'd0, light1_reg} * hsl2rgb_pkg::L_SCALE;

    always_ff @(posedge clk)
    begin
        if (rdy[2])
        begin
            c2_reg    <= c_next;
            x2_reg    <= x_next;
            l6k2_reg  <= l6k_next;
            sext2_reg <= sext1_reg;
        end
    end

    // stage 3: m = L - C/2, place C and X by sextant
    always_comb
    begin
        m_c = l6k2_reg - {1'b0, c2_reg[19:1]};
        case (sext2_reg)
            hsl2rgb_pkg::HUE_S0:
            begin
                comp_c[0] = c2_reg; comp_c[1] = x2_reg; comp_c[2] = '0;
            end
            hsl2rgb_pkg::HUE_S1:
            begin
                comp_c[0] = x2_reg; comp_c[1] = c2_reg; comp_c[2] = '0;
            end
            hsl2rgb_pkg::HUE_S2:
            begin
                comp_c[0] = '0; comp_c[1] = c2_reg; comp_c[2] = x2_reg;
            end
            hsl2rgb_pkg::HUE_S3:
            begin
                comp_c[0] = '0; comp_c[1] = x2_reg; comp_c[2] = c2_reg;
            end
            hsl2rgb_pkg::HUE_S4:
            begin
                comp_c[0] = x2_reg; comp_c[1] = '0; comp_c[2] = c2_reg;
            end
            default:
            begin
                comp_c[0] = c2_reg; comp_c[1] = '0; comp_c[2] = x2_reg;
            end
        endcase
    end

    // stages 3..6 per channel: round(255*v/600000) = floor((17v+20000)/40000)
    for (genvar ch = 0; ch < hsl2rgb_pkg::NUM_CH; ch++)
    begin : g_lane
        logic [20:0] v_next;
        logic [25:0] n_c;
        logic [19:0] a_next;
        logic [38:0] prod_c;
        logic [10:0] q_next;
        logic [7:0]  out_next;

        assign v_next   = {1'b0, comp_c[ch]} + {1'b0, m_c};
        assign n_c      = {5'd0, v3_reg[ch]} * hsl2rgb_pkg::BYTE_MUL + hsl2rgb_pkg::ROUND_BIAS;
        assign a_next   = n_c[25:6];
        // divide by 625: exact reciprocal for 20-bit operands
        assign prod_c   = {19'd0, a4_reg[ch]} * hsl2rgb_pkg::RECIP_625;
        assign q_next   = prod_c[38:28];
        assign out_next = (q5_reg[ch] > hsl2rgb_pkg::BYTE_MAX) ? 8'hFF : q5_reg[ch][7:0];

        always_ff @(posedge clk)
        begin
            if (rdy[3])
            begin
                v3_reg[ch] <= v_next;
            end
            if (rdy[4])
            begin
                a4_reg[ch] <= a_next;
            end
            if (rdy[5])
            begin
                q5_reg[ch] <= q_next;
            end
            if (rdy[6])
            begin
                out6_reg[ch] <= out_next;
            end
        end
    end

    assign red_out   = out6_reg[0];
    assign green_out = out6_reg[1];
    assign blue_out  = out6_reg[2];

    `ASSERT_IMPLIES(a_stall_full, clk, rst_n, in_stall, &vld_reg, "stall with a free stage")
    `ASSERT_NEXT(a_beat_enters, clk, rst_n, in_valid && !in_stall, vld_reg[0], "accepted beat lost at entry")
    `ASSERT_NEXT(a_mid_hold, clk, rst_n, vld_reg[3] && !rdy[4], vld_reg[3], "held beat dropped in pipeline")
    `ASSERT_IMPLIES(a_byte_range, clk, rst_n, vld_reg[5], (q5_reg[0] <= hsl2rgb_pkg::BYTE_MAX) && (q5_reg[1] <= hsl2rgb_pkg::BYTE_MAX) && (q5_reg[2] <= hsl2rgb_pkg::BYTE_MAX), "channel above 255")

endmodule

>>> tb/tb_hsl_to_rgb_converter_unit.sv
`timescale 1ns / 100ps

module tb_hsl_to_rgb_converter_unit;

    localparam int unsigned FRAC_DENOM  = 600000;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned RAND_PER_PH = 633;
    localparam int unsigned NUM_PHASES  = 3;

    typedef struct {
        logic [8:0]  hue;
        logic [6:0]  sat;
        logic [6:0]  light;
        int unsigned phase;
        bit          drain;
    } pixel_t;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    logic [8:0] hue_deg   = '0;
    logic [6:0] sat_pct   = '0;
    logic [6:0] light_pct = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;

    pixel_t      pixel_q[$];
    rgb_t        rgb_q[$];
    int unsigned cur_phase = 0;
    int unsigned err_count = 0;
    int unsigned cycles    = 0;

    int unsigned send_idle_pct[NUM_PHASES]  = '{18, 79, 0};
    int unsigned recv_stall_pct[NUM_PHASES] = '{79, 18, 0};

    hsl_to_rgb_converter_unit u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .hue_deg   (hue_deg),
        .sat_pct   (sat_pct),
        .light_pct (light_pct),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .red_out   (red_out),
        .green_out (green_out),
        .blue_out  (blue_out)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic logic [7:0] frac_to_byte(input longint unsigned v);
        longint unsigned r;
        r = (v * 255 + FRAC_DENOM / 2) / FRAC_DENOM;
        if (r > 255)
            r = 255;
        return r[7:0];
    endfunction

    // All terms are integers over 600000 (100 * 100 * 60).
    function automatic rgb_t hsl_to_rgb(input logic [8:0] hue, input logic [6:0] sat,
                                        input logic [6:0] light);
        longint unsigned    h, s, l, ldist, chroma, rem, tri_w, c, x, m;
        longint unsigned    rc, gc, bc;
        hsl2rgb_pkg::sext_t sx;
        rgb_t               px;
        h = hue;
        s = sat;
        l = light;
        if (h >= hsl2rgb_pkg::HUE_WRAP)
            h = h - hsl2rgb_pkg::HUE_WRAP;
        if (s > hsl2rgb_pkg::PCT_MAX)
            s = hsl2rgb_pkg::PCT_MAX;
        if (l > hsl2rgb_pkg::PCT_MAX)
            l = hsl2rgb_pkg::PCT_MAX;
        ldist  = (2 * l >= 100) ? (2 * l - 100) : (100 - 2 * l);
        chroma = (100 - ldist) * s;
        rem    = h % 120;
        tri_w  = 60 - ((rem >= 60) ? (rem - 60) : (60 - rem));
        c      = chroma * 60;
        x      = chroma * tri_w;
        m      = l * 6000 - chroma * 30;
        sx     = hsl2rgb_pkg::sext_t'(h / 60);
        case (sx)
            hsl2rgb_pkg::HUE_S0: begin rc = c; gc = x; bc = 0; end
            hsl2rgb_pkg::HUE_S1: begin rc = x; gc = c; bc = 0; end
            hsl2rgb_pkg::HUE_S2: begin rc = 0; gc = c; bc = x; end
            hsl2rgb_pkg::HUE_S3: begin rc = 0; gc = x; bc = c; end
            hsl2rgb_pkg::HUE_S4: begin rc = x; gc = 0; bc = c; end
            default:             begin rc = c; gc = 0; bc = x; end
        endcase
        px.red   = frac_to_byte(rc + m);
        px.green = frac_to_byte(gc + m);
        px.blue  = frac_to_byte(bc + m);
        return px;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        err_count++;
    endtask

    task automatic add_pixel(input int unsigned h, input int unsigned s, input int unsigned l,
                             input int unsigned phase, input bit drain);
        pixel_t px;
        px.hue   = 9'(h);
        px.sat   = 7'(s);
        px.light = 7'(l);
        px.phase = phase;
        px.drain = drain;
        pixel_q.push_back(px);
    endtask

    // Driver
    always @(posedge clk)
    begin : drv
        bit     send;
        pixel_t px;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                rgb_q.push_back(hsl_to_rgb(hue_deg, sat_pct, light_pct));
            if (!in_valid || !in_stall)
            begin
                send = pixel_q.size() != 0;
                if (send && pixel_q[0].drain && rgb_q.size() != 0)
                    send = 1'b0;
                if (send && $urandom_range(99) < send_idle_pct[pixel_q[0].phase])
                    send = 1'b0;
                if (send)
                begin
                    px = pixel_q.pop_front();
                    hue_deg   <= px.hue;
                    sat_pct   <= px.sat;
                    light_pct <= px.light;
                    cur_phase <= px.phase;
                    in_valid  <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor
    always @(posedge clk)
    begin : mon
        rgb_t px;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (rgb_q.size() == 0)
                begin
                    report_mismatch("result beat with no expectation pending");
                end
                else
                begin
                    px = rgb_q.pop_front();
                    if (red_out !== px.red)
                        report_mismatch($sformatf("red %0d, want %0d", red_out, px.red));
                    if (green_out !== px.green)
                        report_mismatch($sformatf("green %0d, want %0d", green_out, px.green));
                    if (blue_out !== px.blue)
                        report_mismatch($sformatf("blue %0d, want %0d", blue_out, px.blue));
                end
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct[cur_phase]);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("** hsl_to_rgb_converter_unit: FAILED **");
            $finish;
        end
    end

    initial
    begin : stim
        int unsigned hues[12] = '{0, 59, 60, 119, 120, 180, 240, 300, 359, 360, 361, 511};
        int unsigned h, s, l;
        foreach (hues[i])
            add_pixel(hues[i], 100, 50, 0, 1'b0);
        add_pixel(0, 0, 0, 0, 1'b0);
        add_pixel(200, 100, 100, 0, 1'b0);
        add_pixel(90, 0, 10, 0, 1'b0);      // gray at 25.5, tie goes up
        add_pixel(30, 127, 127, 0, 1'b0);
        add_pixel(150, 101, 101, 0, 1'b0);
        add_pixel(270, 127, 1, 0, 1'b0);
        add_pixel(330, 64, 99, 0, 1'b0);
        add_pixel(45, 100, 0, 0, 1'b0);
        add_pixel(511, 127, 64, 0, 1'b0);
        add_pixel(256, 37, 73, 0, 1'b0);
        for (int unsigned ph = 0; ph < NUM_PHASES; ph++)
        begin
            for (int unsigned i = 0; i < RAND_PER_PH; i++)
            begin
                h = ($urandom_range(9) == 0) ? $urandom_range(511) : $urandom_range(360);
                s = ($urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(100);
                l = ($urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(100);
                add_pixel(h, s, l, ph, (i == 0) || (i == RAND_PER_PH / 2));
            end
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        @(posedge clk);
        while (pixel_q.size() != 0 || in_valid || rgb_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (rgb_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", rgb_q.size()));

        if (err_count == 0)
            $display("** hsl_to_rgb_converter_unit: PASSED **");
        else
            $display("** hsl_to_rgb_converter_unit: FAILED **");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hdl
hdl/hsl2rgb_pkg.sv
hdl/hsl_to_rgb_converter_unit.sv
tb/tb_hsl_to_rgb_converter_unit.sv
